// ===== hdl/outlier_tracking_filter_defines.svh =====
`ifndef OUTLIER_TRACKING_FILTER_DEFINES_SVH
`define OUTLIER_TRACKING_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OTF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/otf_pkg.sv =====
package otf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_SAMPLE_W = 16;
  localparam int VALUE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_W     = 16;
  localparam int WGT_W       = 17;
  localparam int WGT_FRAC_W  = 16;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int PEN_W       = 26;
  localparam int PEN_FRAC_W  = 8;
  localparam int PEN_INT_W   = 5;
  localparam int DEL_SHIFT   = 24;
  localparam int NBR_SHIFT   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int TAB_DEPTH   = 256;
  localparam int INT_DEPTH   = 17;

  localparam logic [PEN_W-1:0]   PEN_MAX    = PEN_W'(4096);
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (WGT_FRAC_W - 1);

  localparam logic [SCALE_W-1:0] DELTA_SCALE_RST = SCALE_W'(3277);
  localparam logic [SCALE_W-1:0] PREV_SCALE_RST  = SCALE_W'(32768);
  localparam logic [SCALE_W-1:0] NEXT_SCALE_RST  = SCALE_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA_SCALE = 2'd0,
    CFG_PREV_SCALE  = 2'd1,
    CFG_NEXT_SCALE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_PREP,
    S_DEL,
    S_PRV,
    S_NXT,
    S_SAT,
    S_WGT,
    S_RND,
    S_STP,
    S_APL,
    S_UPD,
    S_EMIT
  } state_t;

  typedef struct packed {
    state_t step;
    logic   phase;    // 0: result of the pending sample, 1: result of a last sample
    logic   capture;
  } ctrl_t;

  typedef struct packed {
    logic pending_valid;
    logic last;
    logic out_free;
  } stat_t;

  typedef logic [WGT_W-1:0] wgt_tab_t [TAB_DEPTH];
  typedef logic [WGT_W-1:0] int_tab_t [INT_DEPTH];

  // exp(-i), Q1.16
  localparam int_tab_t INT_TAB = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  // exp(-f/256), Q1.16, Taylor series in Q.28 with truncating terms
  function automatic wgt_tab_t gen_frac_tab();
    wgt_tab_t    t;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int f = 0; f < TAB_DEPTH; f++) begin
      x    = 64'(f) << 20;
      term = 64'd1 << 28;
      sum  = term;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x) >> 28) / 64'(k);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      t[f] = WGT_W'((sum + 64'd2048) >> 12);
    end
    return t;
  endfunction

  localparam wgt_tab_t FRAC_TAB = gen_frac_tab();

endpackage

// ===== hdl/otf_if.sv =====
interface otf_in_if import otf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IN_SAMPLE_W-1:0] sample;
  logic                   last_sample;
  logic [VALUE_W-1:0]     start_estimate;

  modport source (output valid, output sample, output last_sample, output start_estimate,
                  input ready);
  modport sink   (input valid, input sample, input last_sample, input start_estimate,
                  output ready);
endinterface

interface otf_out_if import otf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] filtered_value;
  logic               last_result;

  modport source (output valid, output filtered_value, output last_result, input ready);
  modport sink   (input valid, input filtered_value, input last_result, output ready);
endinterface

interface otf_cfg_if import otf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCALE_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/otf_mul.sv =====
module otf_mul import otf_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// ===== hdl/otf_seq.sv =====
`include "outlier_tracking_filter_defines.svh"

module otf_seq import otf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   out_free;

  assign out_free = stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          phase_nxt = 1'b0;
          state_nxt = stat.pending_valid ? S_PREP : S_SEED;
        end
      end
      S_SEED: begin
        phase_nxt = 1'b1;
        state_nxt = stat.last ? S_PREP : S_IDLE;
      end
      S_PREP: state_nxt = S_DEL;
      S_DEL:  state_nxt = S_PRV;
      S_PRV:  state_nxt = S_NXT;
      S_NXT:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_WGT;
      S_WGT:  state_nxt = S_RND;
      S_RND:  state_nxt = S_STP;
      S_STP:  state_nxt = S_APL;
      S_APL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (!phase_r && stat.last) begin
            phase_nxt = 1'b1;
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    ctrl.step    = state_r;
    ctrl.phase   = phase_r;
    ctrl.capture = (state_r == S_IDLE) && in_valid;
  end

  `OTF_ASSERT_NEXT(a_dispatch, state_r == S_IDLE && in_valid, state_r == S_SEED || state_r == S_PREP, "request not dispatched")
  `OTF_ASSERT_NEXT(a_emit_hold, state_r == S_EMIT && !out_free, state_r == S_EMIT && $stable(phase_r), "result dropped under stall")
  `OTF_ASSERT_NEXT(a_last_done, state_r == S_EMIT && out_free && phase_r, state_r == S_IDLE, "extra pass after last result")

endmodule

// ===== hdl/otf_dp.sv =====
`include "outlier_tracking_filter_defines.svh"

module otf_dp import otf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_t                  ctrl,
  output stat_t                  stat,
  input  logic [IN_SAMPLE_W-1:0] in_sample,
  input  logic                   in_last,
  input  logic [VALUE_W-1:0]     in_start,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [VALUE_W-1:0]     out_value,
  output logic                   out_last
);

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(input logic [SAMPLE_BITS-1:0] x,
                                                      input logic [SAMPLE_BITS-1:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  logic [SCALE_W-1:0]     delta_scale_r, prev_scale_r, next_scale_r;
  logic [SAMPLE_BITS-1:0] samp_in_r;
  logic                   last_in_r;
  logic [VALUE_W-1:0]     start_in_r;
  logic [VALUE_W-1:0]     running_r;
  logic [SAMPLE_BITS-1:0] pending_r, preceding_r;
  logic                   pending_valid_r, preceding_valid_r;
  logic [VALUE_W-1:0]     mag_r;
  logic                   neg_r;
  logic [PEN_W-1:0]       pen_r;
  logic [WGT_W-1:0]       w_r;
  logic [VALUE_W-1:0]     step_r;
  logic                   out_valid_r;
  logic [VALUE_W-1:0]     out_value_r;
  logic                   out_last_r;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_W-1:0]     sv;
  logic                   sv_below;
  logic [PEN_W-1:0]       nbr_term;
  logic [PEN_W-1:0]       pen_sum;
  logic [PROD_W-1:0]      prod_rnd;
  logic                   out_free;
  logic                   emit_fire;

  assign out_free  = !out_valid_r || out_ready;
  assign emit_fire = (ctrl.step == S_EMIT) && out_free;

  assign sv       = VALUE_W'(pending_r) << FRAC_BITS;
  assign sv_below = running_r > sv;
  assign nbr_term = PEN_W'(prod >> NBR_SHIFT);
  assign pen_sum  = pen_r + (ctrl.phase ? '0 : nbr_term);
  assign prod_rnd = prod + ROUND_HALF;

  always_comb begin
    unique case (ctrl.step)
      S_DEL: begin
        mul_a = mag_r;
        mul_b = MUL_B_W'(delta_scale_r);
      end
      S_PRV: begin
        mul_a = MUL_A_W'(abs_diff(pending_r, preceding_r));
        mul_b = MUL_B_W'(prev_scale_r);
      end
      S_NXT: begin
        mul_a = MUL_A_W'(abs_diff(pending_r, samp_in_r));
        mul_b = MUL_B_W'(next_scale_r);
      end
      S_WGT: begin
        mul_a = MUL_A_W'(INT_TAB[pen_r[PEN_FRAC_W +: PEN_INT_W]]);
        mul_b = FRAC_TAB[pen_r[PEN_FRAC_W-1:0]];
      end
      S_STP: begin
        mul_a = mag_r;
        mul_b = w_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_scale_r <= DELTA_SCALE_RST;
      prev_scale_r  <= PREV_SCALE_RST;
      next_scale_r  <= NEXT_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELTA_SCALE: delta_scale_r <= cfg_data;
        CFG_PREV_SCALE:  prev_scale_r  <= cfg_data;
        CFG_NEXT_SCALE:  next_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      samp_in_r  <= in_sample[SAMPLE_BITS-1:0];
      last_in_r  <= in_last;
      start_in_r <= in_start;
    end
  end

  // history of the waveform
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r   <= 1'b0;
      preceding_valid_r <= 1'b0;
    end else if (ctrl.step == S_SEED) begin
      pending_valid_r   <= 1'b1;
      preceding_valid_r <= 1'b0;
    end else if (emit_fire) begin
      pending_valid_r   <= !ctrl.phase;
      preceding_valid_r <= !ctrl.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step == S_SEED) begin
      pending_r <= samp_in_r;
    end else if (emit_fire && !ctrl.phase) begin
      preceding_r <= pending_r;
      pending_r   <= samp_in_r;
    end
  end

  // penalty, weight, step and running estimate
  always_ff @(posedge clk) begin
    unique case (ctrl.step)
      S_SEED: running_r <= start_in_r;
      S_PREP: begin
        neg_r <= sv_below;
        mag_r <= sv_below ? running_r - sv : sv - running_r;
      end
      S_PRV: pen_r <= PEN_W'(prod >> DEL_SHIFT);
      S_NXT: begin
        if (preceding_valid_r) begin
          pen_r <= pen_r + nbr_term;
        end
      end
      S_SAT: pen_r <= (pen_sum > PEN_MAX) ? PEN_MAX : pen_sum;
      S_RND: w_r <= WGT_W'(prod_rnd >> WGT_FRAC_W);
      S_APL: step_r <= VALUE_W'(prod_rnd >> WGT_FRAC_W);
      S_UPD: running_r <= neg_r ? running_r - step_r : running_r + step_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value_r <= running_r;
      out_last_r  <= ctrl.phase;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  always_comb begin
    stat.pending_valid = pending_valid_r;
    stat.last          = last_in_r;
    stat.out_free      = out_free;
  end

  `OTF_ASSERT_SAME(a_pen_sat, ctrl.step == S_WGT, pen_r <= PEN_MAX, "penalty above saturation")
  `OTF_ASSERT_NEXT(a_last_clear, emit_fire && ctrl.phase, !pending_valid_r && !preceding_valid_r, "history kept after last result")
  `OTF_ASSERT_NEXT(a_seed_hist, ctrl.step == S_SEED, pending_valid_r && !preceding_valid_r, "seed left bad history")

endmodule

// ===== hdl/outlier_tracking_filter.sv =====
// channel   dir  handshake      payload
// in_chan   in   valid / ready  sample, last_sample, start_estimate
// out_chan  out  valid / ready  filtered_value, last_result
// cfg_chan  in   valid / ready  index, data (ready tied high)
//
// A first sample seeds the history and gives no result unless it is also last.
// Each result is computed on the one shared 32x17 multiplier; a last sample
// flushes two results, one for the pending sample and one for itself.
// in_chan.ready is high only while the sequencer is idle; a stalled result holds it in emit.
// Synchronous rst_n restores the default scales and forgets the sample history.
module outlier_tracking_filter import otf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  otf_in_if.sink     in_chan,
  otf_out_if.source  out_chan,
  otf_cfg_if.sink    cfg_chan
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_chan.ready = 1'b1;

  otf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  otf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_sample (in_chan.sample),
    .in_last   (in_chan.last_sample),
    .in_start  (in_chan.start_estimate),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_value (out_chan.filtered_value),
    .out_last  (out_chan.last_result)
  );

endmodule
